/* rtl/ascending_integer_sorter_top_defines.svh */
// ----------------------------------------------------------------------------
// ascending integer sorter assertion macros
// shared property wrappers for the sorter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASCENDING_INTEGER_SORTER_TOP_DEFINES_SVH
`define ASCENDING_INTEGER_SORTER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define AIS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorter check failed");

// next-cycle implication, disabled in reset
`define AIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorter check failed");

`endif

/* rtl/ais_pkg.sv */
// ----------------------------------------------------------------------------
// ais_pkg
// shared widths, defaults and cell types of the ascending integer sorter
// ----------------------------------------------------------------------------
package ais_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned MaxItemsDef = 64;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the incoming element
    logic pop;  // shift the row one place toward cell zero
  } cell_ctrl_t;

  // contents of one cell as seen by a neighbor
  typedef struct packed {
    logic                     valid;
    logic signed [DataW-1:0]  value;
  } cell_t;

endpackage

/* rtl/ais_if.sv */
// ----------------------------------------------------------------------------
// ais interfaces
// valid/ready channels for the sorter's input and result beats
// ----------------------------------------------------------------------------
interface ais_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ais_pkg::DataW-1:0]     value;
  logic                                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ais_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ais_pkg::DataW-1:0]     sorted_value;
  logic                                 final_res;
  logic                                 overflowed;

  modport source (output valid, output sorted_value, output final_res,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input final_res,
                  input overflowed, output ready);
endinterface

/* rtl/ais_cell.sv */
// ----------------------------------------------------------------------------
// ais_cell
// one slot of the insertion chain: keeps one element, shifts right on
// insert, shifts left on drain
// ----------------------------------------------------------------------------
module ais_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ais_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [ais_pkg::DataW-1:0]  elem_i,
  input  logic                              left_less_i,
  input  ais_pkg::cell_t                    left_i,
  input  ais_pkg::cell_t                    right_i,
  output logic                              less_o,
  output ais_pkg::cell_t                    cell_o
);

  logic                              valid_q, valid_d;
  logic signed [ais_pkg::DataW-1:0]  value_q, value_d;

  // an empty slot counts as larger than anything
  assign less_o = !valid_q || (elem_i < value_q);

  // next contents
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.pop) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else if (ctrl_i.ins && less_o) begin
      if (left_less_i) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = elem_i;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // element storage
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.value = value_q;

endmodule

/* rtl/ascending_integer_sorter_top.sv */
// ----------------------------------------------------------------------------
// ascending_integer_sorter_top
// sorts one run of signed 32-bit elements with a chain of insertion cells
// ----------------------------------------------------------------------------
// While a run is filling, one element is taken every cycle: each beat is
// compared against all MAX_ITEMS cells at once and slots into place in the
// same cycle. The beat flagged last closes the run; from the next cycle the
// row drains through cell zero, one result beat per cycle of downstream
// ready, and while it drains the input is held off. Elements beyond
// MAX_ITEMS are dropped and every result of that run carries the overflow
// flag. Input reopens right after the final result beat is taken.
`include "ascending_integer_sorter_top_defines.svh"

module ascending_integer_sorter_top #(
  parameter int unsigned MAX_ITEMS = ais_pkg::MaxItemsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ais_in_if.sink          in_i,
  ais_out_if.source       out_o
);

  ais_pkg::cell_ctrl_t  ctrl;
  ais_pkg::cell_t       cells [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] less;
  logic [MAX_ITEMS-1:0] vld;
  logic                 drain_q, drain_d;
  logic                 ovf_q, ovf_d;
  logic                 in_acc;
  logic                 full;
  logic                 done;

  // handshake and row commands
  assign full     = vld[MAX_ITEMS-1];
  assign in_i.ready = !drain_q;
  assign in_acc   = in_i.valid && in_i.ready;
  assign ctrl.ins = in_acc && !full;
  assign ctrl.pop = drain_q && out_o.ready;
  assign done     = ctrl.pop && !vld[1];

  // the insertion chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    ais_pkg::cell_t left_c;
    ais_pkg::cell_t right_c;
    logic           left_less;

    if (i == 0) begin : g_first
      assign left_c    = '0;
      assign left_less = 1'b0;
    end else begin : g_mid
      assign left_c    = cells[i-1];
      assign left_less = less[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_body
      assign right_c = cells[i+1];
    end

    ais_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .elem_i      (in_i.value),
      .left_less_i (left_less),
      .left_i      (left_c),
      .right_i     (right_c),
      .less_o      (less[i]),
      .cell_o      (cells[i])
    );

    assign vld[i] = cells[i].valid;
  end

  // run control: drain phase and overflow flag
  always_comb begin
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (in_acc && full) begin
      ovf_d = 1'b1;
    end
    if (in_acc && in_i.last) begin
      drain_d = 1'b1;
    end
    if (done) begin
      drain_d = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  // result beat straight from cell zero
  assign out_o.valid        = drain_q;
  assign out_o.sorted_value = cells[0].value;
  assign out_o.final_res    = !vld[1];
  assign out_o.overflowed   = ovf_q;

  // occupied cells always form a prefix of the row
  `AIS_ASSERT_IMPL(a_prefix, 1'b1, (vld & (vld + 1'b1)) == '0)
  // no input beat is taken while results are pending
  `AIS_ASSERT_IMPL(a_no_overlap, out_o.valid, !in_i.ready)
  // closing the run starts the drain
  `AIS_ASSERT_NEXT(a_drain_start, in_i.valid && in_i.ready && in_i.last, out_o.valid)
  // results keep coming in ascending order until the final one
  `AIS_ASSERT_NEXT(a_ascending, out_o.valid && out_o.ready && !out_o.final_res,
                   out_o.valid && !(out_o.sorted_value < $past(out_o.sorted_value)))

endmodule
